// ----- hdl/alr_pkg.sv -----
package alr_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COORD_BITS = 16;
	localparam int ALPHA_BITS = 8;
	localparam int DIM_BITS   = 13;

	// minor coordinate gets two guard bits: floor+1 of a line ending near the top
	// of the coordinate range must not wrap for the clipping test
	localparam int MINOR_BITS    = COORD_BITS + 2;
	localparam int ACC_BITS      = MINOR_BITS + FRAC_BITS;
	localparam int GRAD_BITS     = FRAC_BITS + 2;
	localparam int DIVIDEND_BITS = COORD_BITS + FRAC_BITS;
	localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(1024);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PIX0,
		ST_PIX1
	} state_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [ALPHA_BITS-1:0] alpha;
		logic                  in_image;
	} pix_t;

endpackage

// ----- hdl/alr_divider.sv -----
module alr_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [alr_pkg::DIVIDEND_BITS-1:0]    dividend,
	input  logic [alr_pkg::COORD_BITS-1:0]       divisor,
	output logic                                 done,
	output logic [alr_pkg::GRAD_BITS-2:0]        quotient
);
	import alr_pkg::*;

	localparam logic [DIV_CNT_BITS-1:0] LAST_ITER = DIV_CNT_BITS'(DIVIDEND_BITS - 1);

	logic                      run_q;
	logic                      done_q;
	logic [DIV_CNT_BITS-1:0]   cnt_q;
	logic [COORD_BITS-1:0]     rem_q;
	logic [COORD_BITS-1:0]     dvs_q;
	logic [DIVIDEND_BITS-1:0]  quo_q;

	logic [COORD_BITS:0] shifted;
	logic [COORD_BITS:0] diff;
	logic                take;

	// one quotient bit a cycle, restoring form
	assign shifted = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign take    = ~diff[COORD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == LAST_ITER);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_ITER)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= take ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[GRAD_BITS-2:0];

endmodule

// ----- hdl/alr_pixel.sv -----
module alr_pixel (
	input  logic                                 sel_upper,
	input  logic                                 x_major,
	input  logic signed [alr_pkg::COORD_BITS-1:0] major_pos,
	input  logic signed [alr_pkg::ACC_BITS-1:0]   acc,
	input  logic [alr_pkg::ALPHA_BITS-1:0]       alpha,
	input  logic [alr_pkg::DIM_BITS-1:0]         image_width,
	input  logic [alr_pkg::DIM_BITS-1:0]         image_height,
	output alr_pkg::pix_t                        pix
);
	import alr_pkg::*;

	localparam int WEIGHT_BITS = FRAC_BITS + 1;
	localparam int PROD_BITS   = ALPHA_BITS + WEIGHT_BITS;
	localparam logic [WEIGHT_BITS-1:0] ONE  = WEIGHT_BITS'(1) << FRAC_BITS;
	localparam logic [PROD_BITS-1:0]   HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

	logic signed [MINOR_BITS-1:0] floor_v;
	logic signed [MINOR_BITS-1:0] minor;
	logic signed [MINOR_BITS-1:0] major_ext;
	logic signed [MINOR_BITS-1:0] px;
	logic signed [MINOR_BITS-1:0] py;
	logic [FRAC_BITS-1:0]         frac;
	logic [WEIGHT_BITS-1:0]       weight;
	logic [PROD_BITS-1:0]         prod;
	logic                         x_in;
	logic                         y_in;

	assign floor_v   = acc[ACC_BITS-1:FRAC_BITS];
	assign frac      = acc[FRAC_BITS-1:0];
	assign minor     = sel_upper ? floor_v + MINOR_BITS'(1) : floor_v;
	assign major_ext = MINOR_BITS'(major_pos);
	assign px        = x_major ? major_ext : minor;
	assign py        = x_major ? minor : major_ext;

	assign weight = sel_upper ? {1'b0, frac} : ONE - {1'b0, frac};
	assign prod   = PROD_BITS'(alpha) * PROD_BITS'(weight) + HALF;

	// clipping on the unwrapped coordinate
	assign x_in = ~px[MINOR_BITS-1] &&
		(px[MINOR_BITS-2:0] < (MINOR_BITS-1)'(image_width));
	assign y_in = ~py[MINOR_BITS-1] &&
		(py[MINOR_BITS-2:0] < (MINOR_BITS-1)'(image_height));

	always_comb begin
		pix.x        = px[COORD_BITS-1:0];
		pix.y        = py[COORD_BITS-1:0];
		pix.alpha    = prod[FRAC_BITS+ALPHA_BITS-1:FRAC_BITS];
		pix.in_image = x_in && y_in;
	end

endmodule

// ----- hdl/antialiased_line_rasterizer_core.sv -----
// Start item: accepted, then (unless the line has zero length) the shift-subtract divider
//   runs one quotient bit a cycle, 32 bits; the block takes no new item until it is done.
// Step item: accept, floor pixel, floor+1 pixel, weighted in turn through one
//   coverage multiplier, plus any cycles the result side stalls.
// arst_n clears the sequencer, line state and output valid; width and height
//   return to 1024.
module antialiased_line_rasterizer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  alr_pkg::cmd_t                         command,
	input  logic signed [alr_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [alr_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [alr_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [alr_pkg::COORD_BITS-1:0] end_y,
	input  logic [alr_pkg::ALPHA_BITS-1:0]        line_alpha,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [alr_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [alr_pkg::COORD_BITS-1:0] pixel_y,
	output logic [alr_pkg::ALPHA_BITS-1:0]        pixel_alpha,
	output logic                                  inside_image,
	output logic                                  last_of_step,
	output logic                                  line_finished,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  alr_pkg::cfg_reg_t                     cfg_index,
	input  logic [alr_pkg::DIM_BITS-1:0]          cfg_data
);
	import alr_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam logic signed [GRAD_BITS-1:0] GRAD_MAX = GRAD_BITS'(1) << FRAC_BITS;

	state_t state_q, state_d;

	logic [DIM_BITS-1:0]           width_q;
	logic [DIM_BITS-1:0]           height_q;
	logic                          active_q;
	logic                          x_major_q;
	logic                          neg_q;
	logic signed [COORD_BITS-1:0]  major_pos_q;
	logic signed [COORD_BITS-1:0]  major_end_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [GRAD_BITS-1:0]   grad_q;
	logic [ALPHA_BITS-1:0]         alpha_q;

	logic  out_valid_q;
	pix_t  pix_q;
	logic  last_q;
	logic  fin_q;

	logic in_fire;
	logic slot_free;
	logic load_out;
	logic div_start;
	logic div_done;
	logic [GRAD_BITS-2:0] quot;

	// setup arithmetic on the start item
	logic signed [DW-1:0] dx, dy, adx, ady;
	logic signed [DW-1:0] ma0, ma1, mi0, mi1, sma0, sma1, smi0, smi1;
	logic signed [DW-1:0] den, num, anum;
	logic                 x_major_d;
	logic [DIVIDEND_BITS-1:0] dividend;

	always_comb begin
		dx   = DW'(end_x) - DW'(start_x);
		dy   = DW'(end_y) - DW'(start_y);
		adx  = dx[DW-1] ? -dx : dx;
		ady  = dy[DW-1] ? -dy : dy;
		x_major_d = adx > ady;
		ma0  = x_major_d ? DW'(start_x) : DW'(start_y);
		ma1  = x_major_d ? DW'(end_x)   : DW'(end_y);
		mi0  = x_major_d ? DW'(start_y) : DW'(start_x);
		mi1  = x_major_d ? DW'(end_y)   : DW'(end_x);
		if (ma1 < ma0) begin
			sma0 = ma1; sma1 = ma0; smi0 = mi1; smi1 = mi0;
		end else begin
			sma0 = ma0; sma1 = ma1; smi0 = mi0; smi1 = mi1;
		end
		den  = sma1 - sma0;
		num  = smi1 - smi0;
		anum = num[DW-1] ? -num : num;
		dividend = {anum[COORD_BITS-1:0], FRAC_BITS'(0)} +
			DIVIDEND_BITS'(den[COORD_BITS-1:1]);
	end

	logic signed [COORD_BITS:0] pos_next;
	logic                       fin;
	pix_t                       pix;

	assign pos_next = DW'(major_pos_q) + DW'(1);
	assign fin      = pos_next >= DW'(major_end_q);

	alr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den[COORD_BITS-1:0]),
		.done     (div_done),
		.quotient (quot)
	);

	alr_pixel u_pix (
		.sel_upper    (state_q == ST_PIX1),
		.x_major      (x_major_q),
		.major_pos    (major_pos_q),
		.acc          (acc_q),
		.alpha        (alpha_q),
		.image_width  (width_q),
		.image_height (height_q),
		.pix          (pix)
	);

	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (command == CMD_START)
						state_d = (den != '0) ? ST_DIV : ST_IDLE;
					else
						state_d = active_q ? ST_PIX0 : ST_IDLE;
				end
			end
			ST_DIV:  state_d = div_done ? ST_IDLE : ST_DIV;
			ST_PIX0: state_d = slot_free ? ST_PIX1 : ST_PIX0;
			ST_PIX1: state_d = slot_free ? ST_IDLE : ST_PIX1;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		load_out  = ((state_q == ST_PIX0) || (state_q == ST_PIX1)) && slot_free;
		div_start = in_fire && (command == CMD_START) && (den != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			width_q     <= DIM_RESET;
			height_q    <= DIM_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
					CFG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_fire && command == CMD_START)
				active_q <= 1'b0;
			else if (state_q == ST_DIV && div_done)
				active_q <= 1'b1;
			else if (state_q == ST_PIX1 && slot_free && fin)
				active_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && command == CMD_START) begin
			x_major_q   <= x_major_d;
			neg_q       <= num[DW-1];
			major_pos_q <= sma0[COORD_BITS-1:0];
			major_end_q <= sma1[COORD_BITS-1:0];
			acc_q       <= {ACC_BITS'(smi0[COORD_BITS-1:0]) << FRAC_BITS} |
				({ACC_BITS{smi0[COORD_BITS-1]}} << (COORD_BITS + FRAC_BITS));
			alpha_q     <= line_alpha;
		end
		if (state_q == ST_DIV && div_done)
			grad_q <= neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		if (state_q == ST_PIX1 && slot_free) begin
			major_pos_q <= pos_next[COORD_BITS-1:0];
			acc_q       <= acc_q + ACC_BITS'(grad_q);
		end
		if (load_out) begin
			pix_q  <= pix;
			last_q <= (state_q == ST_PIX1);
			fin_q  <= fin;
		end
	end

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign pixel_x       = pix_q.x;
	assign pixel_y       = pix_q.y;
	assign pixel_alpha   = pix_q.alpha;
	assign inside_image  = pix_q.in_image;
	assign last_of_step  = last_q;
	assign line_finished = fin_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside division state");

	a_grad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && state_q != ST_DIV) |-> (grad_q <= GRAD_MAX && grad_q >= -GRAD_MAX))
		else $error("gradient magnitude above one");

	a_pix_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIX0 || state_q == ST_PIX1) |-> active_q)
		else $error("pixel emission without an active line");

endmodule

// ----- sim/antialiased_line_rasterizer_core_test.sv -----
module antialiased_line_rasterizer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import alr_pkg::*;

	localparam int     DRAIN_CYCLES = 48;
	localparam longint TIMEOUT_NS   = 15_000_000;
	localparam longint FIX_ONE      = longint'(1) <<< FRAC_BITS;
	localparam longint FIX_HALF     = FIX_ONE / 2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [ALPHA_BITS-1:0]        alpha;
		logic                         in_image;
		logic                         last;
		logic                         fin;
	} pixel_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	cmd_t                         command;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [ALPHA_BITS-1:0]        line_alpha;
	logic                         out_valid;
	logic                         out_ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic [ALPHA_BITS-1:0]        pixel_alpha;
	logic                         inside_image;
	logic                         last_of_step;
	logic                         line_finished;
	logic                         cfg_valid;
	logic                         cfg_ready;
	cfg_reg_t                     cfg_index;
	logic [DIM_BITS-1:0]          cfg_data;

	// line walker copy
	bit                  line_on;
	bit                  along_x;
	longint              major_pos;
	longint              major_stop;
	longint              minor_acc;
	longint              grad_step;
	logic [ALPHA_BITS-1:0] alpha_held;
	logic [DIM_BITS-1:0] img_w = DIM_RESET;
	logic [DIM_BITS-1:0] img_h = DIM_RESET;

	pixel_t expected_pixels[$];

	int items_sent;
	int lines_started;
	int pixels_checked;
	int cfg_writes;
	int mismatches;
	int sink_hold;
	int sink_stall;
	bit gaps_on = 1'b1;

	antialiased_line_rasterizer_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.line_alpha   (line_alpha),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_alpha  (pixel_alpha),
		.inside_image (inside_image),
		.last_of_step (last_of_step),
		.line_finished(line_finished),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int rand_range(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return rand_range(1, 3);
		if (r < 97)
			return rand_range(4, 12);
		return rand_range(20, 60);
	endfunction

	function automatic logic [ALPHA_BITS-1:0] rand_alpha();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return ALPHA_BITS'($urandom);
	endfunction

	function automatic logic [DIM_BITS-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return DIM_BITS'(1);
		if (r < 20)
			return DIM_BITS'(4096);
		if (r < 25)
			return DIM_BITS'(8191);
		return DIM_BITS'(rand_range(1, 4096));
	endfunction

	function automatic int major_len(int sx, int sy, int ex, int ey);
		int adx, ady;
		adx = (ex > sx) ? ex - sx : sx - ex;
		ady = (ey > sy) ? ey - sy : sy - ey;
		return (adx > ady) ? adx : ady;
	endfunction

	function automatic void emit_pixel(longint minor, longint a, bit last, bit fin);
		longint px, py;
		pixel_t p;
		px = along_x ? major_pos : minor;
		py = along_x ? minor : major_pos;
		p.x      = px[COORD_BITS-1:0];
		p.y      = py[COORD_BITS-1:0];
		p.alpha  = a[ALPHA_BITS-1:0];
		// clip on the unwrapped coordinate
		p.in_image = px >= 0 && px < longint'(img_w) && py >= 0 && py < longint'(img_h);
		p.last   = last;
		p.fin    = fin;
		expected_pixels.push_back(p);
	endfunction

	function automatic void predict_item(cmd_t cmd, logic signed [COORD_BITS-1:0] sx,
			logic signed [COORD_BITS-1:0] sy, logic signed [COORD_BITS-1:0] ex,
			logic signed [COORD_BITS-1:0] ey, logic [ALPHA_BITS-1:0] a);
		longint x0, y0, x1, y1, dx, dy, ma0, ma1, mi0, mi1, t, den, num, mag;
		longint fl, frac, a0, a1;
		bit fin;
		if (cmd == CMD_START) begin
			x0 = sx;
			y0 = sy;
			x1 = ex;
			y1 = ey;
			dx = x1 - x0;
			dy = y1 - y0;
			along_x = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy);
			ma0 = along_x ? x0 : y0;
			ma1 = along_x ? x1 : y1;
			mi0 = along_x ? y0 : x0;
			mi1 = along_x ? y1 : x1;
			if (ma1 < ma0) begin
				t = ma0; ma0 = ma1; ma1 = t;
				t = mi0; mi0 = mi1; mi1 = t;
			end
			den = ma1 - ma0;
			num = mi1 - mi0;
			if (den > 0) begin
				mag = ((((num < 0) ? -num : num) <<< FRAC_BITS) + den / 2) / den;
				grad_step = (num < 0) ? -mag : mag;
			end else begin
				grad_step = 0;
			end
			major_pos  = ma0;
			major_stop = ma1;
			minor_acc  = mi0 <<< FRAC_BITS;
			alpha_held = a;
			line_on    = den > 0;
			return;
		end
		if (!line_on)
			return;
		fl   = minor_acc >>> FRAC_BITS;
		frac = minor_acc & (FIX_ONE - 1);
		a0   = (longint'(alpha_held) * (FIX_ONE - frac) + FIX_HALF) >>> FRAC_BITS;
		a1   = (longint'(alpha_held) * frac + FIX_HALF) >>> FRAC_BITS;
		fin  = major_pos + 1 >= major_stop;
		emit_pixel(fl, a0, 1'b0, fin);
		emit_pixel(fl + 1, a1, 1'b1, fin);
		major_pos = major_pos + 1;
		minor_acc = minor_acc + grad_step;
		if (fin)
			line_on = 1'b0;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel (%0d, %0d) arrived with nothing expected", pixel_x, pixel_y);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("pixel_x", 32'(want.x), 32'(pixel_x));
				check_field("pixel_y", 32'(want.y), 32'(pixel_y));
				check_field("pixel_alpha", 32'(want.alpha), 32'(pixel_alpha));
				check_field("inside_image", 32'(want.in_image), 32'(inside_image));
				check_field("last_of_step", 32'(want.last), 32'(last_of_step));
				check_field("line_finished", 32'(want.fin), 32'(line_finished));
				pixels_checked++;
			end
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (sink_hold > 0) begin
				out_ready <= 1'b0;
				sink_hold--;
			end else if (sink_stall > 0) begin
				out_ready <= 1'b0;
				sink_stall--;
			end else begin
				out_ready <= 1'b1;
				if (gaps_on)
					sink_stall = idle_len();
			end
		end
	end

	task automatic send_item(cmd_t cmd, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
			logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey, logic [ALPHA_BITS-1:0] a);
		int gap;
		gap = gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		start_x    <= sx;
		start_y    <= sy;
		end_x      <= ex;
		end_y      <= ey;
		line_alpha <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_item(cmd, sx, sy, ex, ey, a);
		items_sent++;
	endtask

	// coordinates on a step item are don't-care, so they carry noise
	task automatic send_step();
		send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
			COORD_BITS'($urandom), COORD_BITS'($urandom), ALPHA_BITS'($urandom));
	endtask

	task automatic send_line(int sx, int sy, int ex, int ey,
			logic [ALPHA_BITS-1:0] a, int steps);
		send_item(CMD_START, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex),
			COORD_BITS'(ey), a);
		lines_started++;
		repeat (steps)
			send_step();
	endtask

	// short line in or just around the image; step_adj < 0 abandons it early
	task automatic near_line(int max_len, int step_adj);
		int x0, y0, x1, y1, steps;
		x0 = rand_range(-8, int'(img_w) + 8);
		y0 = rand_range(-8, int'(img_h) + 8);
		x1 = x0 + rand_range(-max_len, max_len);
		y1 = y0 + rand_range(-max_len, max_len);
		steps = major_len(x0, y0, x1, y1) + step_adj;
		if (steps < 0)
			steps = 0;
		send_line(x0, y0, x1, y1, rand_alpha(), steps);
	endtask

	task automatic wait_for_pixels();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	// a start item gives no pixel but keeps the divider busy for a while
	task automatic drain_block();
		wait_for_pixels();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dim(cfg_reg_t idx, logic [DIM_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_IMAGE_WIDTH)
			img_w = val;
		else
			img_h = val;
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic test_directed_cases();
		send_step();                                       // step with no line running
		send_line(5, 5, 5, 5, 8'd200, 1);                  // zero length, step gives nothing
		send_line(0, 0, 3, 1, 8'd255, 3);                  // x major, zero coverage on first step's floor+1 pixel
		send_line(10, 20, 7, 16, 8'd128, 4);               // y major, endpoints swapped
		send_line(0, 0, -50, 50, 8'd0, 2);                 // diagonal, cut short by next start
		send_line(32765, 32767, 32767, 32767, 8'd255, 2);  // floor+1 wraps past the top
		send_line(-32768, -32768, -32767, 32767, 8'd1, 2); // full-range y major
		send_line(-32768, 0, 32767, 0, 8'd255, 2);         // full-range x major
	endtask

	task automatic test_clip_settings();
		logic [DIM_BITS-1:0] widths [5] = '{1, 4096, 0, 1024, 8191};
		logic [DIM_BITS-1:0] heights[5] = '{1, 4096, 1024, 0, 8191};
		for (int i = 0; i < 5; i++) begin
			drain_block();
			write_dim(CFG_IMAGE_WIDTH, widths[i]);
			write_dim(CFG_IMAGE_HEIGHT, heights[i]);
			repeat (6)
				near_line(6, 0);
		end
	endtask

	task automatic test_backpressure();
		sink_hold = 400;
		send_line(0, 5, 80, 37, 8'd200, 80);
		wait_for_pixels();
		gaps_on = 1'b0;
		send_line(100, 2, 40, 60, rand_alpha(), 60);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_lines();
		int r, phase_end;
		for (int phase = 0; phase < 3; phase++) begin
			drain_block();
			write_dim(CFG_IMAGE_WIDTH, pick_dim());
			write_dim(CFG_IMAGE_HEIGHT, pick_dim());
			phase_end = items_sent + 350;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					near_line(24, ($urandom_range(0, 6) == 0) ? 1 : 0);
				end else if (r < 75) begin
					near_line(24, -rand_range(1, 5));
				end else if (r < 88) begin
					send_line($urandom, $urandom, $urandom, $urandom, rand_alpha(),
						rand_range(1, 5));
				end else begin
					repeat (rand_range(1, 3))
						send_step();
				end
			end
		end
	endtask

	initial begin
		int wait_cycles;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		command    <= CMD_START;
		start_x    <= '0;
		start_y    <= '0;
		end_x      <= '0;
		end_y      <= '0;
		line_alpha <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_IMAGE_WIDTH;
		cfg_data   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_cases();
		test_clip_settings();
		test_backpressure();
		test_random_lines();

		in_valid <= 1'b0;
		@(posedge clk);
		wait_cycles = 0;
		while (expected_pixels.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (expected_pixels.size() != 0) begin
			$error("%0d expected pixels never arrived", expected_pixels.size());
			mismatches++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d items over %0d lines, %0d size register writes.",
			items_sent, lines_started, cfg_writes);
		$display("Checked %0d pixels, %0d mismatches.", pixels_checked, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d pixels outstanding.", expected_pixels.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- antialiased_line_rasterizer_core.f -----
hdl/alr_pkg.sv
hdl/alr_divider.sv
hdl/alr_pixel.sv
hdl/antialiased_line_rasterizer_core.sv
sim/antialiased_line_rasterizer_core_test.sv
